// ----- rtl/tkri_pkg.sv -----
// ----------------------------------------------------------------------------
// tkri_pkg
// Shared types and sizes for the ranked insertion table.
// ----------------------------------------------------------------------------
`default_nettype none

package tkri_pkg;

  localparam int TABLE_SIZE = 10;
  localparam int MODE_COUNT = 4;

  localparam int MODE_W  = 2;
  localparam int SCORE_W = 32;
  localparam int LINES_W = 24;
  localparam int TIME_W  = 32;
  localparam int OUT_W   = 4;

  localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
  localparam int RANK_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [LINES_W-1:0] lines;
    logic [TIME_W-1:0]  time_ms;
  } entry_t;

  // Per-cycle control for each cell; valid is per slot, the rest is shared
  typedef struct packed {
    logic              we;
    logic              timed;
    logic              valid;
    logic [MODE_W-1:0] mode;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/top_k_ranked_insert_table_unit.sv -----
// ----------------------------------------------------------------------------
// top_k_ranked_insert_table_unit
// Ranked top-k tables, one per mode, built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with mode, score, lines and time_ms; the item is taken at
//   that edge (busy stays low, so one item can be offered every cycle).
//   Each slot cell compares the candidate against its own entry in parallel
//   and the whole chain shifts in the same cycle.
//   The result appears in the next cycle on the output ports, marked by
//   result_valid_o for exactly one cycle; the receiver cannot stall it.
//   Throughput is 1 item per cycle, set by the single compare-and-shift
//   step of the cell chain.
//   The timed mode register is written through cfg_valid_i/cfg_ready_o;
//   cfg_ready_o is always high. Write it only while idle.
//   Reset empties every table (entry counts to zero) and clears the timed
//   mode register to 0; entry storage itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_ranked_insert_table_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire [tkri_pkg::MODE_W-1:0]   mode_i,
  input  wire [tkri_pkg::SCORE_W-1:0]  score_i,
  input  wire [tkri_pkg::LINES_W-1:0]  lines_i,
  input  wire [tkri_pkg::TIME_W-1:0]   time_ms_i,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [tkri_pkg::MODE_W-1:0]   cfg_data_i,
  output logic                         result_valid_o,
  output logic                         accepted_o,
  output logic [tkri_pkg::OUT_W-1:0]   rank_o,
  output logic [tkri_pkg::OUT_W-1:0]   entry_count_o,
  output logic [tkri_pkg::SCORE_W-1:0] best_score_o,
  output logic [tkri_pkg::LINES_W-1:0] best_lines_o,
  output logic [tkri_pkg::TIME_W-1:0]  best_time_ms_o
);

  localparam int N = tkri_pkg::TABLE_SIZE;

  logic [tkri_pkg::MODE_W-1:0] timed_q;
  logic [tkri_pkg::CNT_W-1:0]  count_q [tkri_pkg::MODE_COUNT];

  logic                        go;
  logic                        mode_ok;
  logic [tkri_pkg::CNT_W-1:0]  n_cur;
  logic [tkri_pkg::CNT_W-1:0]  n_new;
  logic                        ins;
  logic [tkri_pkg::RANK_W-1:0] rank;
  tkri_pkg::entry_t            cand;
  tkri_pkg::entry_t            best;

  tkri_pkg::cell_ctl_t         ctl [N];
  tkri_pkg::entry_t            entry [N];
  logic [N-1:0]                mark;
  logic [N-1:0]                take;

  logic                        valid_q;
  logic                        accepted_q;
  logic [tkri_pkg::RANK_W-1:0] rank_q;
  logic [tkri_pkg::CNT_W-1:0]  count_out_q;
  tkri_pkg::entry_t            best_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign go          = start && !busy;

  assign mode_ok = int'(mode_i) < tkri_pkg::MODE_COUNT;
  assign n_cur   = mode_ok ? count_q[mode_i] : '0;

  assign cand.score   = score_i;
  assign cand.lines   = lines_i;
  assign cand.time_ms = time_ms_i;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign ctl[i].we    = go && mode_ok;
    assign ctl[i].timed = timed_q == mode_i;
    assign ctl[i].valid = tkri_pkg::CNT_W'(i) < n_cur;
    assign ctl[i].mode  = mode_i;

    if (i == 0) begin : g_head
      assign take[i] = mark[i];
      tkri_cell u_cell (
        .clk_i        (clk_i),
        .ctl_i        (ctl[i]),
        .cand_i       (cand),
        .prev_entry_i (cand),
        .prev_mark_i  (1'b0),
        .entry_o      (entry[i]),
        .mark_o       (mark[i])
      );
    end else begin : g_body
      assign take[i] = mark[i] && !mark[i-1];
      tkri_cell u_cell (
        .clk_i        (clk_i),
        .ctl_i        (ctl[i]),
        .cand_i       (cand),
        .prev_entry_i (entry[i-1]),
        .prev_mark_i  (mark[i-1]),
        .entry_o      (entry[i]),
        .mark_o       (mark[i])
      );
    end
  end

  // marks are monotone along the chain, so take has at most one bit set
  always_comb begin
    rank = '0;
    for (int i = 0; i < N; i++) begin
      if (take[i]) begin
        rank = rank | tkri_pkg::RANK_W'(i);
      end
    end
  end

  assign ins   = mode_ok && (|mark);
  assign n_new = (ins && (n_cur < tkri_pkg::CNT_W'(N))) ? n_cur + 1'b1 : n_cur;

  always_comb begin
    if (n_new == '0) begin
      best = '0;
    end else if (ins && take[0]) begin
      best = cand;
    end else begin
      best = entry[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timed_q <= '0;
      valid_q <= 1'b0;
      for (int m = 0; m < tkri_pkg::MODE_COUNT; m++) begin
        count_q[m] <= '0;
      end
    end else begin
      valid_q <= go;
      if (cfg_valid_i && cfg_ready_o) begin
        timed_q <= cfg_data_i;
      end
      if (go && mode_ok) begin
        count_q[mode_i] <= n_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      accepted_q  <= ins;
      rank_q      <= ins ? rank : '0;
      count_out_q <= n_new;
      best_q      <= best;
    end
  end

  assign result_valid_o = valid_q;
  assign accepted_o     = accepted_q;
  assign rank_o         = tkri_pkg::OUT_W'(rank_q);
  assign entry_count_o  = tkri_pkg::OUT_W'(count_out_q);
  assign best_score_o   = best_q.score;
  assign best_lines_o   = best_q.lines;
  assign best_time_ms_o = best_q.time_ms;

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> result_valid_o)
    else $error("item taken without a result");

  a_rank_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && accepted_o) |-> (rank_o < entry_count_o))
    else $error("rank outside the table");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !accepted_o) |-> (entry_count_o == tkri_pkg::OUT_W'(N)))
    else $error("rejected with room left");
`endif

endmodule

`default_nettype wire

// ----- rtl/tkri_cell.sv -----
// ----------------------------------------------------------------------------
// tkri_cell
// One table slot per mode: compares the candidate, takes it or the neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module tkri_cell (
  input  wire                       clk_i,
  input  wire tkri_pkg::cell_ctl_t  ctl_i,
  input  wire tkri_pkg::entry_t     cand_i,
  input  wire tkri_pkg::entry_t     prev_entry_i,
  input  wire                       prev_mark_i,
  output tkri_pkg::entry_t          entry_o,
  output logic                      mark_o
);

  tkri_pkg::entry_t slot_q [tkri_pkg::MODE_COUNT];
  tkri_pkg::entry_t cur;
  logic             ahead;

  assign cur = slot_q[ctl_i.mode];

  always_comb begin
    if (ctl_i.timed) begin
      ahead = cand_i.time_ms < cur.time_ms;
    end else if (cand_i.score != cur.score) begin
      ahead = cand_i.score > cur.score;
    end else begin
      ahead = cand_i.lines > cur.lines;
    end
  end

  // candidate belongs at this slot or earlier; carried down the chain so the
  // first marked slot is the insertion point even if the table order no
  // longer matches the current ranking rule
  assign mark_o  = prev_mark_i || !ctl_i.valid || ahead;
  assign entry_o = cur;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we && mark_o) begin
      slot_q[ctl_i.mode] <= prev_mark_i ? prev_entry_i : cand_i;
    end
  end

endmodule

`default_nettype wire
